>>> hw/rtl/vfsd_pkg.sv
// shared types, constants and register indexes for the video frame sync delay block
package vfsd_pkg;

    localparam int TIME_BITS_DEF = 40;

    localparam int TICKS_W    = 32;
    localparam int REPEAT_W   = 4;
    localparam int FIELD_W    = 40;
    localparam int SCALE_W    = 32;
    localparam int PERIOD_W   = 20;
    localparam int SYNC_W     = 20;
    localparam int NOSYNC_W   = 27;
    localparam int ADV_W      = 24;
    localparam int WAIT_W     = 20;
    localparam int OUT_WAIT_W = 21;
    localparam int PROD_W     = 64;

    localparam int S_DATA_W   = 120;
    localparam int M_DATA_W   = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_TICK_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NOSYNC     = 2'd3;

    localparam logic [SCALE_W-1:0]  TICK_SCALE_RESET = 32'd65536;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET     = 20'd40000;
    localparam logic [SYNC_W-1:0]   SYNC_RESET       = 20'd10000;
    localparam logic [NOSYNC_W-1:0] NOSYNC_RESET     = 27'd10000000;
    localparam logic [WAIT_W-1:0]   WAIT_RESET       = 20'd40000;
    localparam logic [WAIT_W-1:0]   ONE_SECOND_US    = 20'd1000000;
    localparam logic [PROD_W-1:0]   ROUND_HALF       = 64'h8000;

    typedef struct packed {
        logic [SCALE_W-1:0]  tick_scale_q16;
        logic [PERIOD_W-1:0] frame_period_us;
        logic [SYNC_W-1:0]   sync_threshold_us;
        logic [NOSYNC_W-1:0] nosync_threshold_us;
    } cfg_t;

    // fields that ride alongside the timestamp path untouched
    typedef struct packed {
        logic [FIELD_W-1:0] audio_clock_us;
        logic               seek_begin;
        logic [FIELD_W-1:0] seek_target_us;
        logic               has_picture;
    } side_t;

endpackage

>>> hw/rtl/video_frame_sync_delay_top.sv
// video frame sync delay: paces decoded video frames against the audio clock
//
// one item goes in on the s_ side per decoded frame and one result item comes
// out on the m_ side for it, in order. the result says how long to wait before
// the frame is shown, whether a pending seek dropped it, whether a picture goes
// to display, and the resolved presentation time.
// the pipeline has four register stages: input, tick multiply, rounding and
// saturation, then the pacing stage that updates the clock and seek state and
// fills the output register. one item per cycle is accepted and delivered while
// m_tready stays high, as the pacing stage updates the clock and seek state for
// each item as it loads its result.
// when m_tready is low the output register holds its result and the stages
// behind it keep filling until all are full, then s_tready drops.
// reset clears the pipeline valids and returns the video clock, last frame time, seek
// state and configuration to their defaults; last wait returns to 40000 us. the user
// writes configuration through cfg_wr_en/cfg_index/cfg_data while idle; not enforced.
module video_frame_sync_delay_top
#(
    parameter int TIME_BITS = vfsd_pkg::TIME_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // frame_ticks, repeat_count, audio_clock_us, seek_begin, seek_target_us, has_picture
    input  logic [vfsd_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // wait_us, dropped, show_frame, frame_time_us
    output logic [vfsd_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [vfsd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vfsd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    vfsd_pkg::cfg_t                      cfg;

    logic                                in_valid_reg;
    logic                                mul_valid_reg;
    logic                                pts_valid_reg;
    logic                                out_valid_reg;

    logic [vfsd_pkg::TICKS_W-1:0]        ticks_reg;
    logic [vfsd_pkg::REPEAT_W-1:0]       repeat_reg;
    vfsd_pkg::side_t                     side_in_reg;

    logic                                rdy_out;
    logic                                rdy_pts;
    logic                                rdy_mul;
    logic                                rdy_in;

    logic [TIME_BITS-1:0]                pts;
    logic [vfsd_pkg::ADV_W-1:0]          advance;
    vfsd_pkg::side_t                     side_pts;

    logic [vfsd_pkg::OUT_WAIT_W-1:0]     wait_us;
    logic                                dropped;
    logic                                show_frame;
    logic [vfsd_pkg::FIELD_W-1:0]        frame_time_us;

    // each stage takes a new item when it is empty or its item moves on
    assign rdy_out = !out_valid_reg || m_tready;
    assign rdy_pts = !pts_valid_reg || rdy_out;
    assign rdy_mul = !mul_valid_reg || rdy_pts;
    assign rdy_in  = !in_valid_reg  || rdy_mul;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
            pts_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy_in)
                in_valid_reg <= s_tvalid;
            if (rdy_mul)
                mul_valid_reg <= in_valid_reg;
            if (rdy_pts)
                pts_valid_reg <= mul_valid_reg;
            if (rdy_out)
                out_valid_reg <= pts_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_in)
        begin
            ticks_reg                  <= s_tdata[31:0];
            repeat_reg                 <= s_tdata[35:32];
            side_in_reg.audio_clock_us <= s_tdata[75:36];
            side_in_reg.seek_begin     <= s_tdata[76];
            side_in_reg.seek_target_us <= s_tdata[116:77];
            side_in_reg.has_picture    <= s_tdata[117];
        end
    end

    vfsd_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vfsd_scale #(
        .TIME_BITS (TIME_BITS)
    ) u_scale
    (
        .clk             (clk),
        .ld_mul          (rdy_mul),
        .ld_pts          (rdy_pts),
        .frame_ticks     (ticks_reg),
        .repeat_count    (repeat_reg),
        .side_in         (side_in_reg),
        .tick_scale_q16  (cfg.tick_scale_q16),
        .frame_period_us (cfg.frame_period_us),
        .pts             (pts),
        .advance         (advance),
        .side_out        (side_pts)
    );

    vfsd_sync #(
        .TIME_BITS (TIME_BITS)
    ) u_sync
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .ld                  (rdy_out && pts_valid_reg),
        .pts_in              (pts),
        .advance             (advance),
        .side                (side_pts),
        .sync_threshold_us   (cfg.sync_threshold_us),
        .nosync_threshold_us (cfg.nosync_threshold_us),
        .wait_us             (wait_us),
        .dropped             (dropped),
        .show_frame          (show_frame),
        .frame_time_us       (frame_time_us)
    );

    assign s_tready = rdy_in;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, frame_time_us, show_frame, dropped, wait_us};

endmodule

>>> hw/rtl/vfsd_cfg.sv
// configuration register file of the video frame sync delay block
module vfsd_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [vfsd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vfsd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output vfsd_pkg::cfg_t                   cfg
);

    vfsd_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_scale_q16      <= vfsd_pkg::TICK_SCALE_RESET;
            cfg_reg.frame_period_us     <= vfsd_pkg::PERIOD_RESET;
            cfg_reg.sync_threshold_us   <= vfsd_pkg::SYNC_RESET;
            cfg_reg.nosync_threshold_us <= vfsd_pkg::NOSYNC_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                vfsd_pkg::REG_TICK_SCALE:
                    cfg_reg.tick_scale_q16 <= cfg_data[vfsd_pkg::SCALE_W-1:0];
                vfsd_pkg::REG_PERIOD:
                    cfg_reg.frame_period_us <= cfg_data[vfsd_pkg::PERIOD_W-1:0];
                vfsd_pkg::REG_SYNC:
                    cfg_reg.sync_threshold_us <= cfg_data[vfsd_pkg::SYNC_W-1:0];
                vfsd_pkg::REG_NOSYNC:
                    cfg_reg.nosync_threshold_us <= cfg_data[vfsd_pkg::NOSYNC_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/vfsd_scale.sv
// timestamp scaling pipeline: tick multiply, rounding and saturation, clock advance
module vfsd_scale
#(
    parameter int TIME_BITS = vfsd_pkg::TIME_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              ld_mul,
    input  logic                              ld_pts,
    input  logic [vfsd_pkg::TICKS_W-1:0]      frame_ticks,
    input  logic [vfsd_pkg::REPEAT_W-1:0]     repeat_count,
    input  vfsd_pkg::side_t                   side_in,
    input  logic [vfsd_pkg::SCALE_W-1:0]      tick_scale_q16,
    input  logic [vfsd_pkg::PERIOD_W-1:0]     frame_period_us,
    output logic [TIME_BITS-1:0]              pts,
    output logic [vfsd_pkg::ADV_W-1:0]        advance,
    output vfsd_pkg::side_t                   side_out
);

    logic [vfsd_pkg::PROD_W-1:0] prod;
    logic [vfsd_pkg::ADV_W-1:0]  half_rep;
    logic [vfsd_pkg::ADV_W-1:0]  adv;

    logic [vfsd_pkg::PROD_W-1:0] prod_reg;
    logic [vfsd_pkg::ADV_W-1:0]  adv_mul_reg;
    vfsd_pkg::side_t             side_mul_reg;

    logic [vfsd_pkg::PROD_W-1:0] rnd;
    logic [vfsd_pkg::PROD_W-1:0] pts_wide;
    logic                        sat;
    logic [TIME_BITS-1:0]        pts_next;

    logic [TIME_BITS-1:0]        pts_reg;
    logic [vfsd_pkg::ADV_W-1:0]  adv_pts_reg;
    vfsd_pkg::side_t             side_pts_reg;

    assign prod     = {32'd0, frame_ticks} * {32'd0, tick_scale_q16};
    assign half_rep = {4'd0, frame_period_us} * {20'd0, repeat_count};
    // one period plus half a period for each repeat
    assign adv      = {4'd0, frame_period_us} + {1'b0, half_rep[vfsd_pkg::ADV_W-1:1]};

    always_ff @(posedge clk)
    begin
        if (ld_mul)
        begin
            prod_reg     <= prod;
            adv_mul_reg  <= adv;
            side_mul_reg <= side_in;
        end
    end

    // round to nearest, ties up, then clamp to the time range
    assign rnd      = prod_reg + vfsd_pkg::ROUND_HALF;
    assign pts_wide = {16'd0, rnd[vfsd_pkg::PROD_W-1:16]};
    assign sat      = (pts_wide >> TIME_BITS) != 64'd0;
    assign pts_next = sat ? {TIME_BITS{1'b1}} : pts_wide[TIME_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (ld_pts)
        begin
            pts_reg      <= pts_next;
            adv_pts_reg  <= adv_mul_reg;
            side_pts_reg <= side_mul_reg;
        end
    end

    assign pts      = pts_reg;
    assign advance  = adv_pts_reg;
    assign side_out = side_pts_reg;

endmodule

>>> hw/rtl/vfsd_sync.sv
// pacing stage: video clock, seek drop, wait derivation and audio correction
module vfsd_sync
#(
    parameter int TIME_BITS = vfsd_pkg::TIME_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               ld,
    input  logic [TIME_BITS-1:0]               pts_in,
    input  logic [vfsd_pkg::ADV_W-1:0]         advance,
    input  vfsd_pkg::side_t                    side,
    input  logic [vfsd_pkg::SYNC_W-1:0]        sync_threshold_us,
    input  logic [vfsd_pkg::NOSYNC_W-1:0]      nosync_threshold_us,
    output logic [vfsd_pkg::OUT_WAIT_W-1:0]    wait_us,
    output logic                               dropped,
    output logic                               show_frame,
    output logic [vfsd_pkg::FIELD_W-1:0]       frame_time_us
);

    localparam int CW = (TIME_BITS > vfsd_pkg::FIELD_W) ? TIME_BITS : vfsd_pkg::FIELD_W;
    localparam int SW = TIME_BITS + 1;

    logic [TIME_BITS-1:0]              video_clock_reg;
    logic [TIME_BITS-1:0]              last_ft_reg;
    logic [vfsd_pkg::WAIT_W-1:0]       last_wait_reg;
    logic                              seeking_reg;
    logic [vfsd_pkg::FIELD_W-1:0]      seek_target_reg;

    logic [vfsd_pkg::OUT_WAIT_W-1:0]   wait_reg;
    logic                              dropped_reg;
    logic                              show_reg;
    logic [vfsd_pkg::FIELD_W-1:0]      time_reg;

    logic [TIME_BITS-1:0]              pts;
    logic [SW-1:0]                     vc_sum;
    logic [TIME_BITS-1:0]              video_clock_next;
    logic                              seeking_eff;
    logic [vfsd_pkg::FIELD_W-1:0]      target_next;
    logic [CW-1:0]                     pts_x;
    logic [CW-1:0]                     audio_x;
    logic [CW-1:0]                     target_x;
    logic                              drop;
    logic [TIME_BITS-1:0]              gap;
    logic                              gap_ok;
    logic [vfsd_pkg::WAIT_W-1:0]       wait_next;
    logic [CW-1:0]                     mag;
    logic [vfsd_pkg::WAIT_W-1:0]       thr;
    logic                              correct;
    logic [vfsd_pkg::OUT_WAIT_W-1:0]   wait_out;

    // a zero timestamp means unknown: the running clock stands in
    assign pts     = (pts_in != '0) ? pts_in : video_clock_reg;
    assign vc_sum  = {1'b0, pts} + SW'(advance);
    assign video_clock_next = vc_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : vc_sum[TIME_BITS-1:0];

    assign seeking_eff = side.seek_begin | seeking_reg;
    assign target_next = side.seek_begin ? side.seek_target_us : seek_target_reg;

    assign pts_x    = CW'(pts);
    assign audio_x  = CW'(side.audio_clock_us);
    assign target_x = CW'(target_next);
    assign drop     = seeking_eff && (pts_x < target_x);

    assign gap       = pts - last_ft_reg;
    assign gap_ok    = (pts > last_ft_reg) && (gap < TIME_BITS'(vfsd_pkg::ONE_SECOND_US));
    assign wait_next = gap_ok ? gap[vfsd_pkg::WAIT_W-1:0] : last_wait_reg;

    assign mag     = (pts_x >= audio_x) ? (pts_x - audio_x) : (audio_x - pts_x);
    assign thr     = (wait_next > sync_threshold_us) ? wait_next : sync_threshold_us;
    assign correct = (mag < CW'(nosync_threshold_us)) && (mag >= CW'(thr));

    always_comb
    begin
        wait_out = {1'b0, wait_next};
        if (correct)
        begin
            if (pts_x <= audio_x)
                wait_out = '0;
            else
                wait_out = {wait_next, 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            video_clock_reg <= '0;
            last_ft_reg     <= '0;
            last_wait_reg   <= vfsd_pkg::WAIT_RESET;
            seeking_reg     <= 1'b0;
            seek_target_reg <= '0;
        end
        else if (ld)
        begin
            video_clock_reg <= video_clock_next;
            seeking_reg     <= drop;
            seek_target_reg <= target_next;
            if (!drop)
            begin
                last_ft_reg   <= pts;
                last_wait_reg <= wait_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            wait_reg    <= drop ? '0 : wait_out;
            dropped_reg <= drop;
            show_reg    <= !drop && side.has_picture;
            time_reg    <= pts_x[vfsd_pkg::FIELD_W-1:0];
        end
    end

    assign wait_us       = wait_reg;
    assign dropped       = dropped_reg;
    assign show_frame    = show_reg;
    assign frame_time_us = time_reg;

endmodule

>>> dv/tb_top.sv
// testbench for the video frame sync delay block, frames paced by a local model and checked
`timescale 1ns / 100ps

module tb_top;

    localparam int          CYCLE_LIMIT = 500000;
    localparam logic [63:0] TIME_MAX    = (64'd1 << vfsd_pkg::TIME_BITS_DEF) - 64'd1;
    localparam logic [63:0] SECOND_US   = 64'd1000000;

    // first member sits in the top bits, so the struct packs straight into s_tdata
    typedef struct packed {
        logic                          has_picture;
        logic [vfsd_pkg::FIELD_W-1:0]  seek_target_us;
        logic                          seek_begin;
        logic [vfsd_pkg::FIELD_W-1:0]  audio_clock_us;
        logic [vfsd_pkg::REPEAT_W-1:0] repeat_count;
        logic [vfsd_pkg::TICKS_W-1:0]  frame_ticks;
    } video_frame_t;

    typedef struct packed {
        logic [vfsd_pkg::FIELD_W-1:0]    frame_time_us;
        logic                            show_frame;
        logic                            dropped;
        logic [vfsd_pkg::OUT_WAIT_W-1:0] wait_us;
    } pacing_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [vfsd_pkg::S_DATA_W-1:0]   s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [vfsd_pkg::M_DATA_W-1:0]   m_tdata;
    logic                            cfg_wr_en;
    logic [vfsd_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [vfsd_pkg::CFG_DATA_W-1:0] cfg_data;

    // local copy of the registers and pacing state
    vfsd_pkg::cfg_t                  model_cfg;
    logic [vfsd_pkg::FIELD_W-1:0]    video_clock;
    logic [vfsd_pkg::FIELD_W-1:0]    last_frame_time;
    logic [vfsd_pkg::FIELD_W-1:0]    seek_target;
    logic [vfsd_pkg::OUT_WAIT_W-1:0] last_wait;
    logic                            seeking;

    pacing_t pacing_due_q[$];
    int      mismatches   = 0;
    int      cycle_count  = 0;
    int      hold_request = 0;
    bit      send_idle_on = 1'b1;
    bit      recv_idle_on = 1'b1;

    video_frame_sync_delay_top u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [vfsd_pkg::FIELD_W-1:0] rand_time();
        return {8'($urandom), 32'($urandom)};
    endfunction

    function automatic video_frame_t make_frame(input logic [vfsd_pkg::TICKS_W-1:0] ticks,
                                                input logic [vfsd_pkg::REPEAT_W-1:0] rep,
                                                input logic [vfsd_pkg::FIELD_W-1:0] audio,
                                                input logic seek,
                                                input logic [vfsd_pkg::FIELD_W-1:0] target,
                                                input logic pic);
        video_frame_t f;
        f.frame_ticks    = ticks;
        f.repeat_count   = rep;
        f.audio_clock_us = audio;
        f.seek_begin     = seek;
        f.seek_target_us = target;
        f.has_picture    = pic;
        return f;
    endfunction

    // resolves the frame time, moves the video clock and seek state, derives the wait
    function automatic pacing_t pace_frame(input video_frame_t f);
        pacing_t     r;
        logic [63:0] pts;
        logic [63:0] step;
        logic [63:0] mag;
        logic [63:0] thr;
        logic [63:0] w;
        logic [63:0] audio;
        audio = 64'(f.audio_clock_us);
        pts = (64'(f.frame_ticks) * 64'(model_cfg.tick_scale_q16)
               + vfsd_pkg::ROUND_HALF) >> 16;
        if (pts > TIME_MAX)
            pts = TIME_MAX;
        if (pts != 64'd0)
            video_clock = pts[vfsd_pkg::FIELD_W-1:0];
        else
            pts = 64'(video_clock);
        step = 64'(model_cfg.frame_period_us)
             + ((64'(model_cfg.frame_period_us) * 64'(f.repeat_count)) >> 1);
        if (64'(video_clock) + step > TIME_MAX)
            video_clock = TIME_MAX[vfsd_pkg::FIELD_W-1:0];
        else
            video_clock = video_clock + step[vfsd_pkg::FIELD_W-1:0];

        if (f.seek_begin)
        begin
            seeking     = 1'b1;
            seek_target = f.seek_target_us;
        end
        r.frame_time_us = pts[vfsd_pkg::FIELD_W-1:0];
        if (seeking)
        begin
            if (pts < 64'(seek_target))
            begin
                r.wait_us    = '0;
                r.dropped    = 1'b1;
                r.show_frame = 1'b0;
                return r;
            end
            seeking = 1'b0;
        end

        // a gap that is not positive or reaches a second keeps the previous wait
        if (pts > 64'(last_frame_time) && pts - 64'(last_frame_time) < SECOND_US)
            w = pts - 64'(last_frame_time);
        else
            w = 64'(last_wait);
        last_wait       = w[vfsd_pkg::OUT_WAIT_W-1:0];
        last_frame_time = pts[vfsd_pkg::FIELD_W-1:0];

        mag = (pts >= audio) ? pts - audio : audio - pts;
        thr = (w > 64'(model_cfg.sync_threshold_us)) ? w : 64'(model_cfg.sync_threshold_us);
        if (mag < 64'(model_cfg.nosync_threshold_us) && mag >= thr)
            w = (pts <= audio) ? 64'd0 : w << 1;
        r.wait_us    = w[vfsd_pkg::OUT_WAIT_W-1:0];
        r.dropped    = 1'b0;
        r.show_frame = f.has_picture;
        return r;
    endfunction

    // offers one frame, waits for it to be taken, then maybe idles a burst
    task automatic send_frame(input video_frame_t f);
        int idle;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, f};
        do
            @(posedge clk);
        while (!s_tready);
        pacing_due_q.push_back(pace_frame(f));
        if (send_idle_on && $urandom_range(0, 4) == 0)
        begin
            idle = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
    endtask

    // stop offering and let every outstanding result drain out of the pipeline
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pacing_due_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic load_registers(input logic [vfsd_pkg::SCALE_W-1:0] scale,
                                  input logic [vfsd_pkg::PERIOD_W-1:0] period,
                                  input logic [vfsd_pkg::SYNC_W-1:0] sync,
                                  input logic [vfsd_pkg::NOSYNC_W-1:0] nosync);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= vfsd_pkg::REG_TICK_SCALE;
        cfg_data  <= scale;
        @(posedge clk);
        model_cfg.tick_scale_q16 = scale;
        cfg_index <= vfsd_pkg::REG_PERIOD;
        cfg_data  <= 32'(period);
        @(posedge clk);
        model_cfg.frame_period_us = period;
        cfg_index <= vfsd_pkg::REG_SYNC;
        cfg_data  <= 32'(sync);
        @(posedge clk);
        model_cfg.sync_threshold_us = sync;
        cfg_index <= vfsd_pkg::REG_NOSYNC;
        cfg_data  <= 32'(nosync);
        @(posedge clk);
        model_cfg.nosync_threshold_us = nosync;
        cfg_wr_en <= 1'b0;
    endtask

    // mostly a plausible stream around a running time, with jumps, seeks and noise
    task automatic run_stream(input int count);
        video_frame_t f;
        logic [63:0]  t_us;
        logic [63:0]  step;
        logic [63:0]  off;
        logic [63:0]  q;
        int           pick;
        int           lean;
        t_us = 64'($urandom_range(0, 20000000));
        for (int i = 0; i < count; i++)
        begin
            pick             = $urandom_range(0, 99);
            f.repeat_count   = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd0;
            f.has_picture    = ($urandom_range(0, 7) != 0);
            f.seek_begin     = 1'b0;
            f.seek_target_us = rand_time();
            step = 64'(model_cfg.frame_period_us)
                 + ((64'(model_cfg.frame_period_us) * 64'(f.repeat_count)) >> 1);
            if (pick < 84)
            begin
                t_us = t_us + step + 64'($urandom_range(0, 3000));
                if (t_us >= 64'd1500)
                    t_us = t_us - 64'd1500;
            end
            if (pick >= 70 && pick < 74)
                t_us = t_us + 64'($urandom_range(1000000, 3000000));
            else if (pick >= 74 && pick < 77)
            begin
                off  = 64'($urandom_range(0, 200000));
                t_us = (t_us > off) ? t_us - off : 64'd0;
            end
            if (pick >= 80 && pick < 84)
            begin
                f.seek_begin     = 1'b1;
                f.seek_target_us = (pick < 83) ? 40'(t_us + 64'($urandom_range(0, 8)) * step)
                                               : 40'(t_us >> 1);
            end
            if (model_cfg.tick_scale_q16 == '0)
                f.frame_ticks = $urandom;
            else
            begin
                q = (t_us << 16) / 64'(model_cfg.tick_scale_q16);
                f.frame_ticks = (q > 64'hFFFF_FFFF) ? '1 : q[vfsd_pkg::TICKS_W-1:0];
            end
            if (pick >= 77 && pick < 80)
                f.frame_ticks = '0;
            lean = $urandom_range(0, 9);
            if (lean < 4)
                off = 64'($urandom_range(0, model_cfg.sync_threshold_us));
            else if (lean < 8)
                off = 64'($urandom_range(0, 150000));
            else if (lean == 8)
                off = 64'(model_cfg.nosync_threshold_us) + 64'($urandom_range(0, 1));
            else
                off = 64'(model_cfg.nosync_threshold_us) - 64'($urandom_range(0, 1));
            if ($urandom_range(0, 1) == 0)
                f.audio_clock_us = 40'(t_us + off);
            else
                f.audio_clock_us = (t_us > off) ? 40'(t_us - off) : '0;
            if (pick >= 84)
            begin
                f.frame_ticks    = $urandom;
                f.repeat_count   = 4'($urandom);
                f.audio_clock_us = rand_time();
                f.seek_begin     = ($urandom_range(0, 9) == 0);
            end
            send_frame(f);
        end
    endtask

    // reset settings, one microsecond per tick
    task automatic test_reset_pacing();
        send_frame(make_frame(32'd40000, 4'd0, 40'd40000, 1'b0, '0, 1'b1));
        // video lags by exactly the wait
        send_frame(make_frame(32'd80000, 4'd0, 40'd120000, 1'b0, '1, 1'b1));
        // video leads by exactly the wait
        send_frame(make_frame(32'd120000, 4'd0, 40'd80000, 1'b0, '0, 1'b1));
        // gap right at the no-sync bound
        send_frame(make_frame(32'd160000, 4'd0, 40'd10160000, 1'b0, '0, 1'b1));
        // unknown timestamp with the most repeats
        send_frame(make_frame(32'd0, 4'd15, 40'd200000, 1'b0, '0, 1'b0));
        // backward timestamp, then a jump of over a second
        send_frame(make_frame(32'd100000, 4'd3, 40'd100000, 1'b0, '0, 1'b1));
        send_frame(make_frame(32'd5000000, 4'd0, 40'd5000000, 1'b0, '0, 1'b1));
        send_frame(make_frame(32'd5040000, 4'd1, 40'd0, 1'b0, '0, 1'b0));
        send_frame(make_frame('1, 4'd0, '1, 1'b0, '1, 1'b1));
    endtask

    task automatic test_seek();
        send_frame(make_frame(32'd6000000, 4'd0, 40'd6000000, 1'b1, 40'd6120000, 1'b1));
        send_frame(make_frame(32'd6040000, 4'd0, 40'd6040000, 1'b0, '0, 1'b1));
        // restart while pending replaces the target
        send_frame(make_frame(32'd6080000, 4'd0, 40'd6080000, 1'b1, 40'd6200000, 1'b1));
        send_frame(make_frame(32'd6200000, 4'd0, 40'd6200000, 1'b0, '0, 1'b1));
        send_frame(make_frame(32'd6240000, 4'd0, 40'd6240000, 1'b1, '1, 1'b1));
        // target behind the frame ends the seek at once
        send_frame(make_frame(32'd6280000, 4'd0, 40'd6300000, 1'b1, '0, 1'b1));
    endtask

    task automatic test_extremes();
        load_registers('1, vfsd_pkg::PERIOD_W'(1000000), vfsd_pkg::SYNC_W'(1000000),
                       vfsd_pkg::NOSYNC_W'(100000000));
        // scaled time and clock advance both saturate
        send_frame(make_frame('1, 4'd15, '0, 1'b0, '0, 1'b1));
        send_frame(make_frame('0, 4'd15, '0, 1'b0, '0, 1'b1));
        send_frame(make_frame(32'd1, 4'd0, '1, 1'b0, '1, 1'b0));
        load_registers('0, '0, '0, '0);
        send_frame(make_frame(32'h5555_5555, 4'd0, 40'h55_5555_5555, 1'b0, '0, 1'b1));
        send_frame(make_frame(32'hAAAA_AAAA, 4'd15, 40'hAA_AAAA_AAAA, 1'b0, '0, 1'b1));
    endtask

    task automatic test_default_stream();
        load_registers(vfsd_pkg::TICK_SCALE_RESET, vfsd_pkg::PERIOD_RESET,
                       vfsd_pkg::SYNC_RESET, vfsd_pkg::NOSYNC_RESET);
        run_stream(350);
    endtask

    // ninety kilohertz ticks, about 11.11 us each
    task automatic test_ninety_khz();
        load_registers(vfsd_pkg::SCALE_W'(728178), vfsd_pkg::PERIOD_W'(33367),
                       vfsd_pkg::SYNC_RESET, vfsd_pkg::NOSYNC_RESET);
        run_stream(250);
    endtask

    task automatic test_backpressure();
        hold_request = 300;
        send_idle_on = 1'b0;
        run_stream(40);
        send_idle_on = 1'b1;
    endtask

    task automatic test_pause();
        run_stream(60);
        wait_idle();
        run_stream(60);
    endtask

    task automatic test_low_extremes();
        load_registers('0, '0, '0, '0);
        run_stream(60);
        load_registers(vfsd_pkg::SCALE_W'(1), vfsd_pkg::PERIOD_W'(1), '0,
                       vfsd_pkg::NOSYNC_W'(1));
        run_stream(60);
    endtask

    task automatic test_high_extremes();
        load_registers('1, vfsd_pkg::PERIOD_W'(1000000), vfsd_pkg::SYNC_W'(1000000),
                       vfsd_pkg::NOSYNC_W'(100000000));
        run_stream(150);
    endtask

    task automatic test_random_settings();
        repeat (3)
        begin
            load_registers($urandom, vfsd_pkg::PERIOD_W'($urandom_range(0, 1000000)),
                           vfsd_pkg::SYNC_W'($urandom_range(0, 60000)),
                           vfsd_pkg::NOSYNC_W'($urandom_range(0, 100000000)));
            run_stream(130);
        end
    endtask

    task automatic test_quiet_finish();
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        load_registers(vfsd_pkg::SCALE_W'(655360), vfsd_pkg::PERIOD_W'(16683),
                       vfsd_pkg::SYNC_W'(8000), vfsd_pkg::NOSYNC_W'(5000000));
        run_stream(200);
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= vfsd_pkg::REG_TICK_SCALE;
        cfg_data  <= '0;
        model_cfg = '{tick_scale_q16: vfsd_pkg::TICK_SCALE_RESET,
                      frame_period_us: vfsd_pkg::PERIOD_RESET,
                      sync_threshold_us: vfsd_pkg::SYNC_RESET,
                      nosync_threshold_us: vfsd_pkg::NOSYNC_RESET};
        video_clock     = '0;
        last_frame_time = '0;
        last_wait       = vfsd_pkg::OUT_WAIT_W'(vfsd_pkg::WAIT_RESET);
        seeking         = 1'b0;
        seek_target     = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_pacing();
        test_seek();
        test_extremes();
        test_default_stream();
        test_ninety_khz();
        test_backpressure();
        test_pause();
        test_low_extremes();
        test_high_extremes();
        test_random_settings();
        test_quiet_finish();
        wait_idle();

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // result side: compares each item with the oldest expected pacing, then picks tready
    initial
    begin : result_check
        pacing_t got;
        pacing_t want;
        int      stall_left;
        logic    ready_next;
        stall_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got = m_tdata[$bits(pacing_t)-1:0];
                if (pacing_due_q.size() == 0)
                begin
                    $error("result item arrived with no expected pacing waiting");
                    mismatches++;
                end
                else
                begin
                    want = pacing_due_q.pop_front();
                    if (got.wait_us !== want.wait_us)
                    begin
                        $error("wait_us expected %0d got %0d", want.wait_us, got.wait_us);
                        mismatches++;
                    end
                    if (got.dropped !== want.dropped)
                    begin
                        $error("dropped expected %0d got %0d", want.dropped, got.dropped);
                        mismatches++;
                    end
                    if (got.show_frame !== want.show_frame)
                    begin
                        $error("show_frame expected %0d got %0d", want.show_frame,
                               got.show_frame);
                        mismatches++;
                    end
                    if (got.frame_time_us !== want.frame_time_us)
                    begin
                        $error("frame_time_us expected %0d got %0d", want.frame_time_us,
                               got.frame_time_us);
                        mismatches++;
                    end
                end
            end
            // a long hold-off lets the pipeline fill and back up to the input
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                ready_next = 1'b0;
            end
            else if (recv_idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 12) - 1;
                ready_next = 1'b0;
            end
            else
                ready_next = 1'b1;
            m_tready <= ready_next;
        end
    end

    initial
    begin : watchdog
        while (cycle_count <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/vfsd_pkg.sv
hw/rtl/vfsd_cfg.sv
hw/rtl/vfsd_scale.sv
hw/rtl/vfsd_sync.sv
hw/rtl/video_frame_sync_delay_top.sv
dv/tb_top.sv
